@@ hdl/bfr_pkg.sv @@
`default_nettype none

package bfr_pkg;

    // Framing characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_ETB = 8'h17;

    localparam int unsigned SIZE_W = 13;
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned ADDR_W = 3;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 13'd128;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] REG_BLOCK_SIZE = 3'd0;

    typedef enum logic [2:0] {
        EV_DATA   = 3'd0,
        EV_ACK    = 3'd1,
        EV_NAK    = 3'd2,
        EV_END    = 3'd3,
        EV_BADHDR = 3'd4,
        EV_BADTRL = 3'd5
    } t_event_kind;

    typedef struct packed {
        t_event_kind       kind;
        logic [7:0]        data;
        logic [SUM_W-1:0]  computed_sum;
        logic [SUM_W-1:0]  received_sum;
    } t_event;

endpackage

`default_nettype wire

@@ hdl/bfr_core.sv @@
`default_nettype none

module bfr_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_take,
    input  wire logic [7:0]                  i_rx_byte,
    input  wire logic [bfr_pkg::SIZE_W-1:0]  i_block_size,
    output logic                             o_emit,
    output bfr_pkg::t_event                  o_event
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_PAYLOAD = 3'd1,
        PH_TRAILER = 3'd2,
        PH_SUMLO   = 3'd3,
        PH_SUMHI   = 3'd4
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [bfr_pkg::SIZE_W-1:0]    r_seen,  n_seen;
    logic [bfr_pkg::SUM_W-1:0]     r_sum,   n_sum;
    logic [7:0]                    r_lo,    n_lo;
    logic [bfr_pkg::SUM_W-1:0]     w_rsum;

    assign w_rsum = {i_rx_byte, r_lo};

    always_comb begin
        n_phase = r_phase;
        n_seen  = r_seen;
        n_sum   = r_sum;
        n_lo    = r_lo;
        o_emit  = 1'b0;
        o_event.kind         = bfr_pkg::EV_DATA;
        o_event.data         = i_rx_byte;
        o_event.computed_sum = '0;
        o_event.received_sum = '0;
        case (r_phase)
            PH_PAYLOAD: begin
                n_sum  = r_sum + {8'd0, i_rx_byte};
                n_seen = r_seen + 1'b1;
                if (n_seen >= i_block_size) begin
                    n_phase = PH_TRAILER;
                end
                o_emit = 1'b1;
            end
            PH_TRAILER: begin
                n_phase = PH_SUMLO;
                if (i_rx_byte != bfr_pkg::CH_ETB) begin
                    o_emit       = 1'b1;
                    o_event.kind = bfr_pkg::EV_BADTRL;
                end
            end
            PH_SUMLO: begin
                n_lo    = i_rx_byte;
                n_phase = PH_SUMHI;
            end
            PH_SUMHI: begin
                n_phase = PH_HEADER;
                o_emit  = 1'b1;
                o_event.computed_sum = r_sum;
                o_event.received_sum = w_rsum;
                if (w_rsum == r_sum) begin
                    o_event.kind = bfr_pkg::EV_ACK;
                    o_event.data = bfr_pkg::CH_ACK;
                end else begin
                    o_event.kind = bfr_pkg::EV_NAK;
                    o_event.data = bfr_pkg::CH_NAK;
                end
            end
            default: begin
                // header position; stray codes land here too
                n_phase = PH_HEADER;
                if (i_rx_byte == bfr_pkg::CH_ETX) begin
                    o_emit       = 1'b1;
                    o_event.kind = bfr_pkg::EV_END;
                end else if (i_rx_byte != bfr_pkg::CH_STX) begin
                    o_emit       = 1'b1;
                    o_event.kind = bfr_pkg::EV_BADHDR;
                end else begin
                    n_sum   = '0;
                    n_seen  = '0;
                    n_phase = (i_block_size == '0) ? PH_TRAILER : PH_PAYLOAD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_seen  <= '0;
            r_sum   <= '0;
            r_lo    <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
            r_lo    <= n_lo;
        end
    end

endmodule

`default_nettype wire

@@ hdl/block_frame_receiver.sv @@
`default_nettype none

// Block frame receiver: STX, payload, ETB, 16-bit checksum (low byte first).
// Each result is registered and is on the output in the cycle after its byte is accepted.
// The phase machine in bfr_core takes one byte per clock while o_rx_ready is high.
// A single output register parts the sides; o_rx_ready drops only while it is full and stalled.
// Reset (i_rst_n low, synchronous): waiting for header, count and sums zero,
// output empty, block_size back to 128.

module block_frame_receiver (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // APB-style register port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bfr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    // received bytes
    input  wire logic                         i_rx_valid,
    output logic                              o_rx_ready,
    input  wire logic [7:0]                   i_rx_byte,
    // events
    output logic                              o_ev_valid,
    input  wire logic                         i_ev_ready,
    output logic      [2:0]                   o_event_kind,
    output logic      [7:0]                   o_event_byte,
    output logic      [bfr_pkg::SUM_W-1:0]    o_computed_sum,
    output logic      [bfr_pkg::SUM_W-1:0]    o_received_sum
);

    logic [bfr_pkg::SIZE_W-1:0] r_block_size;
    logic                       w_cfg_wr;
    logic                       w_take;
    logic                       w_emit;
    bfr_pkg::t_event            w_event;
    bfr_pkg::t_event            r_event;
    logic                       r_ev_valid;

    // ---- register port: no wait states ----
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= bfr_pkg::BLOCK_SIZE_RST;
        end else if (w_cfg_wr && (paddr == bfr_pkg::REG_BLOCK_SIZE)) begin
            r_block_size <= pwdata[bfr_pkg::SIZE_W-1:0];
        end
    end

    // unmapped addresses read as zero
    assign prdata = (paddr == bfr_pkg::REG_BLOCK_SIZE)
                  ? {{(32-bfr_pkg::SIZE_W){1'b0}}, r_block_size} : 32'd0;

    // ---- input side: take a byte whenever the output slot is free or draining ----
    assign o_rx_ready = !r_ev_valid || i_ev_ready;
    assign w_take     = i_rx_valid && o_rx_ready;

    bfr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_rx_byte    (i_rx_byte),
        .i_block_size (r_block_size),
        .o_emit       (w_emit),
        .o_event      (w_event)
    );

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (o_rx_ready) begin
            // slot free or being taken this edge: refill from the current byte
            r_ev_valid <= w_take && w_emit;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_event <= w_event;
        end
    end

    assign o_ev_valid     = r_ev_valid;
    assign o_event_kind   = r_event.kind;
    assign o_event_byte   = r_event.data;
    assign o_computed_sum = r_event.computed_sum;
    assign o_received_sum = r_event.received_sum;

endmodule

`default_nettype wire

@@ hdl/bfr_checker.sv @@
`default_nettype none

module bfr_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         o_rx_ready,
    input  wire logic                         o_ev_valid,
    input  wire logic                         i_ev_ready,
    input  wire logic [2:0]                   o_event_kind,
    input  wire logic [7:0]                   o_event_byte,
    input  wire logic [bfr_pkg::SUM_W-1:0]    o_computed_sum,
    input  wire logic [bfr_pkg::SUM_W-1:0]    o_received_sum
);

    // stalled event holds
    a_ev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid && !i_ev_ready |=> o_ev_valid && $stable(o_event_kind)
            && $stable(o_event_byte) && $stable(o_computed_sum)
            && $stable(o_received_sum))
        else $error("event changed while stalled");

    // empty output slot never blocks input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ev_valid |-> o_rx_ready)
        else $error("input stalled with empty output");

    // ACK reply carries matching sums, NAK differing ones
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid && (o_event_kind == bfr_pkg::EV_ACK) |->
            (o_event_byte == bfr_pkg::CH_ACK) && (o_computed_sum == o_received_sum))
        else $error("bad ACK event");

    a_nak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid && (o_event_kind == bfr_pkg::EV_NAK) |->
            (o_event_byte == bfr_pkg::CH_NAK) && (o_computed_sum != o_received_sum))
        else $error("bad NAK event");

    // sums only on replies
    a_sums_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid && (o_event_kind != bfr_pkg::EV_ACK)
            && (o_event_kind != bfr_pkg::EV_NAK) |->
            (o_computed_sum == '0) && (o_received_sum == '0))
        else $error("sums set on non-reply event");

endmodule

bind block_frame_receiver bfr_checker u_bfr_checker (.*);

`default_nettype wire
